@@ sv/stvk_peg_pkg.sv @@
package stvk_peg_pkg;

  localparam int NUM_AXES   = 3;
  localparam int IN_W       = 32;
  localparam int IN_DATA_W  = 2 * NUM_AXES * IN_W;
  localparam int OUT_W      = 48;
  localparam int OUT_DATA_W = (NUM_AXES + 1) * OUT_W;
  localparam int OUT_USER_W = 2;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_W-1:0] CFG_RESET  = 32'h0001_0000;
  localparam logic [47:0]      ONE_Q16    = 48'd65536;
  localparam logic [48:0]      THREE_Q16  = 49'd196608;
  localparam logic [60:0]      TERM_CAP   = 61'h1000_0000_0000_0000;
  localparam logic [47:0]      ENERGY_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0]      GRAD_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0]      GRAD_MIN   = 48'h8000_0000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHEAR   = 2'd0,
    REG_LAME    = 2'd1,
    REG_PENALTY = 2'd2
  } reg_idx_t;

  // Four 32x24 partial products of a 64-bit by 48-bit unsigned product.
  typedef struct packed {
    logic [55:0] ll;
    logic [55:0] lh;
    logic [55:0] hl;
    logic [55:0] hh;
  } pp_t;

  function automatic pp_t pp_form(input logic [63:0] a, input logic [47:0] b);
    pp_t p;
    p.ll = 56'(a[31:0])  * 56'(b[23:0]);
    p.lh = 56'(a[31:0])  * 56'(b[47:24]);
    p.hl = 56'(a[63:32]) * 56'(b[23:0]);
    p.hh = 56'(a[63:32]) * 56'(b[47:24]);
    return p;
  endfunction

  function automatic logic [111:0] pp_sum(input pp_t p);
    return 112'(p.ll) + (112'(p.lh) << 24) + (112'(p.hl) << 32) + (112'(p.hh) << 56);
  endfunction

  // Limits a shifted product to 2^60.
  function automatic logic [60:0] cap_term(input logic [111:0] v);
    return (|v[111:60]) ? TERM_CAP : v[60:0];
  endfunction

  function automatic logic [62:0] signed_term(input logic [60:0] m, input logic neg);
    logic [62:0] v;
    v = 63'(m);
    return neg ? (~v + 63'd1) : v;
  endfunction

endpackage

@@ sv/stvk_prox_energy_gradient_unit.sv @@
// St Venant-Kirchhoff energy and gradient with a quadratic proximal penalty.
// Input stream: s_axis_* carries one element per request: three stretches and
// three anchors, signed Q15.16. Output stream: m_axis_* returns the energy
// (unsigned Q32.16) and three gradient components (signed Q31.16) together
// with the negative-stretch and saturation flags.
// The coefficients mu, lambda and k are written through cfg_we/cfg_index/
// cfg_data; the user must write them only while no element is in flight,
// which the block does not enforce; an index of 3 is ignored. Throughput is
// one element per cycle unless the receiver stalls: the eight register
// stages each hold one element, the wide multipliers of stages 4 and 6 are
// cut into 32x24 partial products; each product and wide sum is registered.
// Reset (rst, synchronous) empties the pipeline and sets all coefficients to
// 1.0. When the receiver stalls, the result waits in the output register and
// the stages behind it keep filling; s_axis_tready falls only once every
// stage holds an element. Nothing is dropped or repeated across a stall.
module stvk_prox_energy_gradient_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // stretch_a, stretch_b, stretch_c, anchor_a, anchor_b, anchor_c (32 bits each)
  input  logic [stvk_peg_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // energy_value, grad_a, grad_b, grad_c (48 bits each)
  output logic [stvk_peg_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // negative_stretch, saturated
  output logic [stvk_peg_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  input  logic                                 cfg_we,
  input  logic [stvk_peg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stvk_peg_pkg::CFG_W-1:0]       cfg_data
);
  import stvk_peg_pkg::*;

  localparam int NSTG = 8;

  logic [CFG_W-1:0] shear_modulus;
  logic [CFG_W-1:0] lame_first;
  logic [CFG_W-1:0] penalty_weight;

  logic [NSTG:1] vld;
  logic [NSTG:1] vld_in;
  logic [NSTG:1] rdy;

  // Stage 1: magnitudes of stretches and of stretch minus anchor.
  logic [31:0] s1_ax [NUM_AXES];
  logic        s1_xneg [NUM_AXES];
  logic [32:0] s1_ae [NUM_AXES];
  logic        s1_eneg [NUM_AXES];
  // Stage 2: squares and first coefficient products.
  logic [46:0] s2_m [NUM_AXES];
  logic [47:0] s2_amx [NUM_AXES];
  logic [47:0] s2_alx [NUM_AXES];
  logic [48:0] s2_ak [NUM_AXES];
  logic [32:0] s2_ae [NUM_AXES];
  logic        s2_xneg [NUM_AXES];
  logic        s2_eneg [NUM_AXES];
  // Stage 3: strains and trace.
  logic [46:0] s3_ad [NUM_AXES];
  logic        s3_dneg [NUM_AXES];
  logic [47:0] s3_at;
  logic        s3_tneg;
  logic [47:0] s3_amx [NUM_AXES];
  logic [47:0] s3_alx [NUM_AXES];
  logic [48:0] s3_ak [NUM_AXES];
  logic [32:0] s3_ae [NUM_AXES];
  logic        s3_xneg [NUM_AXES];
  logic        s3_eneg [NUM_AXES];
  // Stage 4: partial products.
  pp_t         s4_pmd [NUM_AXES];
  pp_t         s4_plt;
  pp_t         s4_pg1 [NUM_AXES];
  pp_t         s4_pg2 [NUM_AXES];
  pp_t         s4_pek [NUM_AXES];
  logic [46:0] s4_ad [NUM_AXES];
  logic        s4_dneg [NUM_AXES];
  logic [47:0] s4_at;
  logic        s4_tneg;
  logic [48:0] s4_ak [NUM_AXES];
  logic        s4_xneg [NUM_AXES];
  logic        s4_eneg [NUM_AXES];
  // Stage 5: summed products.
  logic [62:0] s5_amd [NUM_AXES];
  logic [63:0] s5_alt;
  logic [60:0] s5_g1 [NUM_AXES];
  logic [60:0] s5_g2 [NUM_AXES];
  logic [60:0] s5_ek [NUM_AXES];
  logic [46:0] s5_ad [NUM_AXES];
  logic        s5_dneg [NUM_AXES];
  logic [47:0] s5_at;
  logic        s5_tneg;
  logic [48:0] s5_ak [NUM_AXES];
  logic        s5_xneg [NUM_AXES];
  logic        s5_eneg [NUM_AXES];
  // Stage 6: energy partial products, gradient done.
  pp_t         s6_pemd [NUM_AXES];
  pp_t         s6_pelt;
  logic [47:0] s6_grad [NUM_AXES];
  logic        s6_gsat;
  logic [62:0] s6_eksum;
  logic        s6_neg;
  // Stage 7: energy terms.
  logic [60:0] s7_emd [NUM_AXES];
  logic [60:0] s7_elt;
  logic [47:0] s7_grad [NUM_AXES];
  logic        s7_gsat;
  logic [62:0] s7_eksum;
  logic        s7_neg;
  // Stage 8: output register.
  logic [47:0] out_energy;
  logic [47:0] out_grad [NUM_AXES];
  logic        out_neg;
  logic        out_sat;

  // Combinational values feeding the stage registers.
  logic [31:0] c1_ax [NUM_AXES];
  logic        c1_xneg [NUM_AXES];
  logic [32:0] c1_e [NUM_AXES];
  logic [63:0] c2_sq [NUM_AXES];
  logic [63:0] c2_mx [NUM_AXES];
  logic [63:0] c2_lx [NUM_AXES];
  logic [64:0] c2_ke [NUM_AXES];
  logic [47:0] c3_d [NUM_AXES];
  logic [48:0] c3_t;
  logic [62:0] c6_g [NUM_AXES];
  logic [47:0] c6_grad [NUM_AXES];
  logic [NUM_AXES-1:0] c6_gsat;
  logic [62:0] c8_esum;
  logic        c8_over;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      shear_modulus  <= CFG_RESET;
      lame_first     <= CFG_RESET;
      penalty_weight <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SHEAR:   shear_modulus  <= cfg_data;
        REG_LAME:    lame_first     <= cfg_data;
        REG_PENALTY: penalty_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage loads when it is empty or its content moves on in this cycle.
  always_comb begin
    rdy[NSTG] = !vld[NSTG] || m_axis_tready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign vld_in        = {vld[NSTG-1:1], s_axis_tvalid};
  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = vld[NSTG];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld_in[k];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      c1_xneg[i] = s_axis_tdata[IN_W*i + IN_W-1];
      c1_ax[i]   = c1_xneg[i] ? (~s_axis_tdata[IN_W*i +: IN_W] + 32'd1)
                              : s_axis_tdata[IN_W*i +: IN_W];
      c1_e[i]    = {s_axis_tdata[IN_W*i + IN_W-1], s_axis_tdata[IN_W*i +: IN_W]}
                 - {s_axis_tdata[IN_W*(i+NUM_AXES) + IN_W-1],
                    s_axis_tdata[IN_W*(i+NUM_AXES) +: IN_W]};
      c2_sq[i]   = 64'(s1_ax[i]) * 64'(s1_ax[i]);
      c2_mx[i]   = 64'(shear_modulus) * 64'(s1_ax[i]);
      c2_lx[i]   = 64'(lame_first) * 64'(s1_ax[i]);
      c2_ke[i]   = 65'(penalty_weight) * 65'(s1_ae[i]);
      c3_d[i]    = 48'(s2_m[i]) - ONE_Q16;
    end
  end

  // The trace of the strain equals the sum of squares minus three.
  assign c3_t = 49'(s2_m[0]) + 49'(s2_m[1]) + 49'(s2_m[2]) - THREE_Q16;

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      c6_g[i] = signed_term(s5_g1[i], s5_xneg[i] ^ s5_dneg[i])
              + signed_term(s5_g2[i], s5_xneg[i] ^ s5_tneg)
              + signed_term(61'(s5_ak[i]), s5_eneg[i]);
      if (!c6_g[i][62] && (|c6_g[i][61:47])) begin
        c6_grad[i] = GRAD_MAX;
        c6_gsat[i] = 1'b1;
      end else if (c6_g[i][62] && !(&c6_g[i][61:47])) begin
        c6_grad[i] = GRAD_MIN;
        c6_gsat[i] = 1'b1;
      end else begin
        c6_grad[i] = c6_g[i][47:0];
        c6_gsat[i] = 1'b0;
      end
    end
  end

  assign c8_esum = 63'(s7_emd[0]) + 63'(s7_emd[1]) + 63'(s7_emd[2]) + 63'(s7_elt) + s7_eksum;
  assign c8_over = |c8_esum[62:48];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s1_ax[i]   <= c1_ax[i];
        s1_xneg[i] <= c1_xneg[i];
        s1_eneg[i] <= c1_e[i][32];
        s1_ae[i]   <= c1_e[i][32] ? (~c1_e[i] + 33'd1) : c1_e[i];
      end
    end
    if (rdy[2]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s2_m[i]    <= c2_sq[i][62:16];
        s2_amx[i]  <= c2_mx[i][63:16];
        s2_alx[i]  <= c2_lx[i][63:16];
        s2_ak[i]   <= c2_ke[i][64:16];
        s2_ae[i]   <= s1_ae[i];
        s2_xneg[i] <= s1_xneg[i];
        s2_eneg[i] <= s1_eneg[i];
      end
    end
    if (rdy[3]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s3_dneg[i] <= c3_d[i][47];
        s3_ad[i]   <= c3_d[i][47] ? 47'(~c3_d[i] + 48'd1) : c3_d[i][46:0];
        s3_amx[i]  <= s2_amx[i];
        s3_alx[i]  <= s2_alx[i];
        s3_ak[i]   <= s2_ak[i];
        s3_ae[i]   <= s2_ae[i];
        s3_xneg[i] <= s2_xneg[i];
        s3_eneg[i] <= s2_eneg[i];
      end
      s3_tneg <= c3_t[48];
      s3_at   <= c3_t[48] ? 48'(~c3_t + 49'd1) : c3_t[47:0];
    end
    if (rdy[4]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s4_pmd[i]  <= pp_form(64'(shear_modulus), 48'(s3_ad[i]));
        s4_pg1[i]  <= pp_form(64'(s3_amx[i]), 48'(s3_ad[i]));
        s4_pg2[i]  <= pp_form(64'(s3_alx[i]), s3_at);
        s4_pek[i]  <= pp_form(64'(s3_ak[i]), 48'(s3_ae[i]));
        s4_ad[i]   <= s3_ad[i];
        s4_dneg[i] <= s3_dneg[i];
        s4_ak[i]   <= s3_ak[i];
        s4_xneg[i] <= s3_xneg[i];
        s4_eneg[i] <= s3_eneg[i];
      end
      s4_plt  <= pp_form(64'(lame_first), s3_at);
      s4_at   <= s3_at;
      s4_tneg <= s3_tneg;
    end
    if (rdy[5]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s5_amd[i]  <= 63'(pp_sum(s4_pmd[i]) >> 16);
        s5_g1[i]   <= cap_term(pp_sum(s4_pg1[i]) >> 16);
        s5_g2[i]   <= cap_term(pp_sum(s4_pg2[i]) >> 17);
        s5_ek[i]   <= cap_term(pp_sum(s4_pek[i]) >> 17);
        s5_ad[i]   <= s4_ad[i];
        s5_dneg[i] <= s4_dneg[i];
        s5_ak[i]   <= s4_ak[i];
        s5_xneg[i] <= s4_xneg[i];
        s5_eneg[i] <= s4_eneg[i];
      end
      s5_alt  <= 64'(pp_sum(s4_plt) >> 16);
      s5_at   <= s4_at;
      s5_tneg <= s4_tneg;
    end
    if (rdy[6]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s6_pemd[i] <= pp_form(64'(s5_amd[i]), 48'(s5_ad[i]));
        s6_grad[i] <= c6_grad[i];
      end
      s6_pelt  <= pp_form(s5_alt, s5_at);
      s6_gsat  <= |c6_gsat;
      s6_eksum <= 63'(s5_ek[0]) + 63'(s5_ek[1]) + 63'(s5_ek[2]);
      s6_neg   <= s5_xneg[0] | s5_xneg[1] | s5_xneg[2];
    end
    if (rdy[7]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        s7_emd[i]  <= cap_term(pp_sum(s6_pemd[i]) >> 18);
        s7_grad[i] <= s6_grad[i];
      end
      s7_elt   <= cap_term(pp_sum(s6_pelt) >> 19);
      s7_gsat  <= s6_gsat;
      s7_eksum <= s6_eksum;
      s7_neg   <= s6_neg;
    end
    if (rdy[8]) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        out_grad[i] <= s7_grad[i];
      end
      // A negative stretch forces the energy to its maximum without counting
      // as saturation.
      out_energy <= (s7_neg || c8_over) ? ENERGY_MAX : c8_esum[47:0];
      out_neg    <= s7_neg;
      out_sat    <= s7_gsat | (!s7_neg && c8_over);
    end
  end

  assign m_axis_tdata = {out_grad[2], out_grad[1], out_grad[0], out_energy};
  assign m_axis_tuser = {out_sat, out_neg};

  a_neg_energy_max: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[47:0] == ENERGY_MAX)
    else $error("negative stretch without maximum energy");

  a_stage_handoff: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] && rdy[NSTG] |=> vld[NSTG])
    else $error("element lost between the last two stages");

  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (&vld))
    else $error("input stalled while a pipeline stage is empty");

  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(vld[NSTG-1]))
    else $error("result appeared without an element behind it");

endmodule
